>>> hw/rtl/split_field_by_delimiter_defines.svh
// Assertion macros for the field splitter checker.
`ifndef SPLIT_FIELD_BY_DELIMITER_DEFINES_SVH
`define SPLIT_FIELD_BY_DELIMITER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sfd_pkg.sv
// Shared constants, register codes and result type for the field splitter.
package sfd_pkg;

   localparam int MAX_DELIMITER = 8;
   // window cells actually used: the length register never selects more than 8
   localparam int LEN_CAP       = (MAX_DELIMITER < 8) ? MAX_DELIMITER : 8;
   localparam int FILL_W        = $clog2(LEN_CAP + 1);
   // one emitted byte plus a full window flush
   localparam int NUM_RES       = LEN_CAP + 1;
   localparam int RES_W         = $clog2(NUM_RES + 1);
   localparam int QUEUE_DEPTH   = LEN_CAP + 2;
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W     = 2;

   localparam logic [63:0] DELIM_BYTES_RESET = 64'd44;
   localparam logic [3:0]  DELIM_LEN_RESET   = 4'd1;
   localparam logic [31:0] FIELD_NUM_RESET   = 32'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELIM_BYTES = 2'd0,
      CSR_DELIM_LEN   = 2'd1,
      CSR_FIELD_NUM   = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
      logic       is_null;
   } sfd_item_type;

endpackage

>>> hw/rtl/split_field_by_delimiter.sv
// Top level of the streaming field splitter (split by delimiter, pick one field).
//
//  Channel   Direction  Handshake            Carries
//  req_      in         req_valid/req_stall  one string byte, present flag, last flag
//  rsp_      out        rsp_valid/rsp_stall  one field byte or end marker, null flag
//  csr_      in         csr_valid/csr_ready  register index and 64-bit write data
//
// One req_ transfer per cycle. Each byte steps the window chain (one cell per
// delimiter byte) by one place; the whole-window compare is done in parallel.
// The final byte of a string may queue up to LEN_CAP + 1 results, which the
// output chain drains one per unstalled cycle; req_stall is high while more
// than one result waits. Synchronous reset restores the registers (',' / 1 / 1)
// and empties the queue; there is no clearing pass. csr_ready is always high.
module split_field_by_delimiter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_in_byte,
   input  logic                         req_byte_present,
   input  logic                         req_last_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_out_present,
   output logic                         rsp_end_of_result,
   output logic                         rsp_result_null,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                  csr_data
);
   import sfd_pkg::*;

   // configuration registers
   logic [63:0] dbytes_ff;
   logic [3:0]  dlen_ff;
   logic [31:0] fnum_ff;

   // stream state
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       ctr_ff, ctr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   // window chain: cell 0 holds the newest byte, cell j the byte j places older
   logic [7:0]         win_cur  [LEN_CAP];
   logic [7:0]         win_next [LEN_CAP];
   logic [7:0]         win_prev [LEN_CAP];
   logic [7:0]         win_cmp  [LEN_CAP];
   logic [LEN_CAP-1:0] win_hit;

   // step control
   logic              acc, pop;
   logic              fn_neg, step, push, win_full, sel, has_emit, match, mismatch;
   logic [FILL_W-1:0] len, fill_c, fill_push, fill_step, flush_n;
   logic [31:0]       ctr_step;
   logic [7:0]        emit_byte;
   logic [RES_W-1:0]  m_raw, res_n;
   logic [QCNT_W-1:0] base;

   sfd_item_type new_item  [NUM_RES];
   sfd_item_type slot_q    [QUEUE_DEPTH];
   sfd_item_type slot_up   [QUEUE_DEPTH];
   sfd_item_type slot_ld   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] slot_load;

   assign csr_ready = 1'b1;
   assign acc       = req_valid && !req_stall;
   assign pop       = (cnt_ff != '0) && !rsp_stall;
   assign req_stall = (cnt_ff > QCNT_W'(1));

   // ---- configuration writes; indexes past the list are dropped ----
   always_ff @(posedge clock) begin
      if (reset) begin
         dbytes_ff <= DELIM_BYTES_RESET;
         dlen_ff   <= DELIM_LEN_RESET;
         fnum_ff   <= FIELD_NUM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DELIM_BYTES: dbytes_ff <= csr_data;
            CSR_DELIM_LEN:   dlen_ff   <= csr_data[3:0];
            CSR_FIELD_NUM:   fnum_ff   <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // ---- window chain ----
   always_comb begin
      win_prev[0] = req_in_byte;
      for (int j = 1; j < LEN_CAP; j++) begin
         win_prev[j] = win_cur[j-1];
      end
   end

   // after a shift, cell j holds window position len-1-j, so it meets that delimiter byte
   always_comb begin
      for (int j = 0; j < LEN_CAP; j++) begin
         win_cmp[j] = '0;
         for (int k = 0; k < LEN_CAP; k++) begin
            if (k + j + 1 == int'(len)) begin
               win_cmp[j] = dbytes_ff[8*k +: 8];
            end
         end
      end
   end

   for (genvar g = 0; g < LEN_CAP; g++) begin : g_win
      sfd_win_cell u_cell (
         .clock     (clock),
         .shift_en  (push),
         .prev_byte (win_prev[g]),
         .cmp_byte  (win_cmp[g]),
         .cur_byte  (win_cur[g]),
         .next_byte (win_next[g]),
         .hit       (win_hit[g])
      );
   end

   // ---- one string step ----
   always_comb begin
      len = (dlen_ff > 4'(LEN_CAP)) ? FILL_W'(LEN_CAP) : FILL_W'(dlen_ff);
      fn_neg = fnum_ff[31];
      // a negative field swallows everything but the last item; an empty non-last item is a no-op
      step = acc && !fn_neg && (req_byte_present || req_last_byte);
      // a shortened delimiter drops the oldest bytes
      fill_c   = (fill_ff > len) ? len : fill_ff;
      win_full = (len != '0) && (fill_c == len);
      sel      = (ctr_ff == fnum_ff);
      push     = step && req_byte_present && (len != '0);

      emit_byte = req_in_byte;
      if (len != '0) begin
         for (int j = 0; j < LEN_CAP; j++) begin
            if (j + 1 == int'(len)) begin
               emit_byte = win_cur[j];
            end
         end
      end
      has_emit  = step && req_byte_present && ((len == '0) || (win_full && sel));
      fill_push = win_full ? len : fill_c + FILL_W'(1);

      mismatch = 1'b0;
      for (int j = 0; j < LEN_CAP; j++) begin
         if ((j < int'(len)) && !win_hit[j]) begin
            mismatch = 1'b1;
         end
      end
      match = push && (fill_push == len) && !mismatch;

      if (!step || (len == '0)) begin
         fill_step = (len == '0) && step ? '0 : fill_ff;
      end else if (push) begin
         fill_step = match ? '0 : fill_push;
      end else begin
         fill_step = fill_c;
      end

      ctr_step = (match && (ctr_ff != '1)) ? ctr_ff + 32'd1 : ctr_ff;
      flush_n  = (step && req_last_byte && (len != '0) && (ctr_step == fnum_ff))
                 ? fill_step : '0;
      m_raw    = RES_W'(has_emit) + RES_W'(flush_n);
      if (!acc) begin
         res_n = '0;
      end else if (req_last_byte && (m_raw == '0)) begin
         res_n = RES_W'(1);   // empty or null end marker
      end else begin
         res_n = m_raw;
      end

      fill_in = (acc && req_last_byte) ? '0 : fill_step;
      ctr_in  = (acc && req_last_byte) ? 32'd1 : ctr_step;
   end

   // results of this step, oldest first: emitted byte, then the flushed window
   always_comb begin
      int kk;
      for (int p = 0; p < NUM_RES; p++) begin
         kk = p - int'(has_emit);
         new_item[p] = '0;
         if (has_emit && (p == 0)) begin
            new_item[p].data    = emit_byte;
            new_item[p].present = 1'b1;
         end else if ((kk >= 0) && (kk < int'(flush_n))) begin
            for (int j = 0; j < LEN_CAP; j++) begin
               if (j + kk + 1 == int'(fill_step)) begin
                  new_item[p].data = win_next[j];
               end
            end
            new_item[p].present = 1'b1;
         end
         new_item[p].last    = req_last_byte && (p + 1 == int'(res_n));
         new_item[p].is_null = fn_neg && req_last_byte;
      end
   end

   // ---- result queue chain ----
   // new results land just above what survives this cycle's pop (at most one)
   assign base   = cnt_ff - QCNT_W'(pop);
   assign cnt_in = base + (acc ? QCNT_W'(res_n) : '0);

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_out
      if (g == 0) begin : g_bottom
         assign slot_ld[g] = (base != '0) ? '0 : new_item[g];
      end else if (g < NUM_RES) begin : g_mid
         assign slot_ld[g] = (base != '0) ? new_item[g-1] : new_item[g];
      end else begin : g_top
         assign slot_ld[g] = (base != '0) ? new_item[g-1] : '0;
      end

      if (g < QUEUE_DEPTH - 1) begin : g_up
         assign slot_up[g] = slot_q[g+1];
      end else begin : g_none
         assign slot_up[g] = '0;
      end

      assign slot_load[g] = acc && (g >= int'(base)) && (g - int'(base) < int'(res_n));

      sfd_out_cell u_cell (
         .clock      (clock),
         .pop        (pop),
         .load       (slot_load[g]),
         .upper_item (slot_up[g]),
         .load_item  (slot_ld[g]),
         .item       (slot_q[g])
      );
   end

   assign rsp_valid         = (cnt_ff != '0);
   assign rsp_out_byte      = slot_q[0].data;
   assign rsp_out_present   = slot_q[0].present;
   assign rsp_end_of_result = slot_q[0].last;
   assign rsp_result_null   = slot_q[0].is_null;

   // ---- control state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ctr_ff  <= 32'd1;
         cnt_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         ctr_ff  <= ctr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/sfd_win_cell.sv
// One byte cell of the delimiter window shift chain, with its compare.
module sfd_win_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] prev_byte,
   input  logic [7:0] cmp_byte,
   output logic [7:0] cur_byte,
   output logic [7:0] next_byte,
   output logic       hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   assign byte_in   = shift_en ? prev_byte : byte_ff;
   assign next_byte = byte_in;
   assign cur_byte  = byte_ff;
   // compare against the delimiter byte this cell lines up with after the shift
   assign hit       = (byte_in == cmp_byte);

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

>>> hw/rtl/sfd_out_cell.sv
// One slot of the result queue chain; slot 0 drives the result port.
module sfd_out_cell (
   input  logic                  clock,
   input  logic                  pop,
   input  logic                  load,
   input  sfd_pkg::sfd_item_type upper_item,
   input  sfd_pkg::sfd_item_type load_item,
   output sfd_pkg::sfd_item_type item
);
   import sfd_pkg::*;

   sfd_item_type item_ff;
   sfd_item_type item_in;

   always_comb begin
      priority if (load) begin
         item_in = load_item;
      end else if (pop) begin
         item_in = upper_item;
      end else begin
         item_in = item_ff;
      end
   end

   assign item = item_ff;

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

>>> hw/rtl/sfd_checker.sv
// Port-level checks for the field splitter, bound to the top level.
`include "split_field_by_delimiter_defines.svh"

module sfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_present,
   input logic       rsp_end_of_result,
   input logic       rsp_result_null
);

   logic [10:0] rsp_payload;
   logic        rsp_held;
   logic        rsp_empty_end;

   assign rsp_payload   = {rsp_out_byte, rsp_out_present, rsp_end_of_result, rsp_result_null};
   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_empty_end = rsp_end_of_result && !rsp_out_present && (rsp_out_byte == 8'd0);

   // a held result keeps its payload
   `SFD_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_payload), "held result moved")
   // null result is a lone end marker
   `SFD_ASSERT_NOW(a_null_marker, rsp_valid && rsp_result_null, rsp_empty_end, "bad null result")
   // an item with no byte only ever closes a result
   `SFD_ASSERT_NOW(a_empty_is_end, rsp_valid && !rsp_out_present, rsp_empty_end, "stray empty item")
   // input back-pressure only comes from queued results
   `SFD_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid, "input stalled with empty queue")

endmodule

bind split_field_by_delimiter sfd_checker u_sfd_checker (.*);
